[design/tcg_pkg.sv]
package tcg_pkg;

  localparam int XW = 13;
  localparam int YW = 16;
  localparam int PITCH_W = 14;
  localparam int ADDR_W = 48;
  localparam int COLOUR_W = 32;
  localparam int FONT_IDX_W = 12;
  localparam int OFF_W = YW + PITCH_W + 1;
  localparam int ROW_W = 4;

  localparam logic [7:0] CODE_NEWLINE = 8'd10;
  localparam logic [7:0] CODE_BLOCK = 8'd7;
  localparam logic [XW-1:0] CELL_W = 13'd8;
  localparam logic [YW-1:0] CELL_H = 16'd16;
  localparam logic [ROW_W-1:0] ROW_LAST = 4'd15;

  localparam logic [2:0] REG_BASE = 3'd0;
  localparam logic [2:0] REG_WIDTH = 3'd1;
  localparam logic [2:0] REG_HEIGHT = 3'd2;
  localparam logic [2:0] REG_PITCH = 3'd3;
  localparam logic [2:0] REG_CLEAR = 3'd4;

  typedef enum logic [1:0] {
    OP_PRINT = 2'd0,
    OP_LOAD  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_ERASE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_ROW    = 2'd0,
    KIND_SCROLL = 2'd1,
    KIND_FILL   = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    MASK_FONT = 2'd0,
    MASK_ONES = 2'd1,
    MASK_ZERO = 2'd2
  } mask_t;

  typedef struct packed {
    logic [XW-1:0] x;
    logic [YW-1:0] y;
    logic          scroll;
  } cell_t;

endpackage

[design/tcg_cmd_if.sv]
interface tcg_cmd_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    op;
  logic [7:0]                    char_code;
  logic [tcg_pkg::COLOUR_W-1:0]  ink_colour;
  logic [tcg_pkg::FONT_IDX_W-1:0] font_index;
  logic [7:0]                    font_byte;

  modport source (output valid, op, char_code, ink_colour, font_index, font_byte,
                  input ready);
  modport sink (input valid, op, char_code, ink_colour, font_index, font_byte,
                output ready);
endinterface

[design/tcg_res_if.sv]
interface tcg_res_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   kind;
  logic [tcg_pkg::ADDR_W-1:0]   row_address;
  logic [7:0]                   pixel_mask;
  logic [tcg_pkg::COLOUR_W-1:0] pixel_colour;
  logic                         last;

  modport source (output valid, kind, row_address, pixel_mask, pixel_colour, last,
                  input ready);
  modport sink (input valid, kind, row_address, pixel_mask, pixel_colour, last,
                output ready);
endinterface

[design/text_console_glyph_renderer.sv]
// Text console renderer for a 32-bit-per-pixel framebuffer.
// Commands arrive on in_ch and results leave on out_ch; both are valid/ready
// channels, and a transaction completes when valid and ready are both high.
// Registers are written through the APB port (8-byte spacing); pready is tied
// high, and registers should only be written while the block is idle.
// A printed character or an erase gives sixteen row writes, one per cycle
// while the receiver takes them. Scroll and fill requests give a single
// result; font loads and plain newlines give no result, and they too wait
// in the command stage until the row sequencer is free.
// A command passes the command stage, the row sequencer and the output register.
// One further command is held while the sequencer is busy, so the input
// can accept a command while a finished result waits at the output register.
// When the receiver stalls, the output register holds and the sequencer
// and font read wait with it; the input stops once its holding stage fills.
// Reset homes the cursor and restores the register defaults; the font
// store is not cleared and glyph rows must be loaded before use.
module text_console_glyph_renderer #(
  parameter int GLYPH_COUNT = 256,
  parameter int GLYPH_ROWS = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  tcg_cmd_if.sink          in_ch,
  tcg_res_if.source        out_ch,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [5:0]       paddr,
  input  logic [63:0]      pwdata,
  output logic [63:0]      prdata,
  output logic             pready
);

  localparam int FONT_DEPTH = GLYPH_COUNT * GLYPH_ROWS;
  localparam int FONT_AW = $clog2(FONT_DEPTH);

  typedef enum logic [1:0] {
    JOB_NONE,
    JOB_LOAD,
    JOB_ROWS,
    JOB_SINGLE
  } jcls_t;

  logic [tcg_pkg::ADDR_W-1:0]   base_r;
  logic [tcg_pkg::XW-1:0]       width_r;
  logic [tcg_pkg::XW-1:0]       height_r;
  logic [tcg_pkg::PITCH_W-1:0]  pitch_r;
  logic [tcg_pkg::COLOUR_W-1:0] clear_r;

  logic                           job_valid_r;
  jcls_t                          job_cls_r, job_cls_nxt;
  tcg_pkg::kind_t                 job_kind_r, job_kind_nxt;
  tcg_pkg::mask_t                 job_mode_r, job_mode_nxt;
  logic [tcg_pkg::COLOUR_W-1:0]   job_colour_r, job_colour_nxt;
  logic [tcg_pkg::OFF_W-1:0]      job_off_r, job_off_nxt;
  logic [FONT_AW-1:0]             job_faddr_r;
  logic [tcg_pkg::FONT_IDX_W-1:0] job_fidx_r;
  logic [7:0]                     job_fbyte_r;

  logic                         em_active_r;
  logic                         em_single_r;
  logic [tcg_pkg::ROW_W-1:0]    em_cnt_r;
  tcg_pkg::kind_t               em_kind_r;
  tcg_pkg::mask_t               em_mode_r;
  logic [tcg_pkg::COLOUR_W-1:0] em_colour_r;
  logic [tcg_pkg::ADDR_W-1:0]   em_addr_r;
  logic [FONT_AW-1:0]           em_faddr_r;

  logic                         out_valid_r;
  tcg_pkg::kind_t               out_kind_r;
  tcg_pkg::mask_t               out_mode_r;
  logic [tcg_pkg::ADDR_W-1:0]   out_addr_r;
  logic [tcg_pkg::COLOUR_W-1:0] out_colour_r;
  logic                         out_last_r;

  logic                       in_take, job_take, em_step, em_last, e2_adv, cfg_wr;
  tcg_pkg::op_t               in_op;
  tcg_pkg::cell_t             pos;
  logic [FONT_AW+7:0]         faddr_full;
  logic [7:0]                 font_q;
  logic                       font_we;
  logic [tcg_pkg::ADDR_W-1:0] stride;
  tcg_pkg::mask_t             row_mode;

  assign in_op = tcg_pkg::op_t'(in_ch.op);
  assign e2_adv = !out_valid_r || out_ch.ready;
  assign em_last = em_single_r || (em_cnt_r == tcg_pkg::ROW_LAST);
  assign em_step = em_active_r && e2_adv;
  assign job_take = job_valid_r && (!em_active_r || (em_step && em_last));
  assign in_ch.ready = !job_valid_r || job_take;
  assign in_take = in_ch.valid && in_ch.ready;
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;
  assign stride = {{(tcg_pkg::ADDR_W - tcg_pkg::PITCH_W - 2){1'b0}}, pitch_r, 2'b00};
  assign faddr_full = {{FONT_AW{1'b0}}, in_ch.char_code} * (FONT_AW + 8)'(GLYPH_ROWS);
  assign font_we = job_take && (job_cls_r == JOB_LOAD)
                   && ({1'b0, job_fidx_r} < 13'(FONT_DEPTH));
  assign row_mode = ((em_mode_r == tcg_pkg::MASK_FONT)
                     && ({1'b0, em_cnt_r} >= 5'(GLYPH_ROWS))) ? tcg_pkg::MASK_ZERO
                                                               : em_mode_r;

  tcg_cursor u_cursor (
    .clk           (clk),
    .rst_n         (rst_n),
    .take          (in_take),
    .op            (in_op),
    .char_code     (in_ch.char_code),
    .screen_width  (width_r),
    .screen_height (height_r),
    .pos           (pos)
  );

  tcg_ram #(
    .WIDTH (8),
    .DEPTH (FONT_DEPTH)
  ) u_font (
    .clk   (clk),
    .we    (font_we),
    .waddr (job_fidx_r[FONT_AW-1:0]),
    .wdata (job_fbyte_r),
    .re    (em_step),
    .raddr (em_faddr_r),
    .rdata (font_q)
  );

  always_comb begin
    job_cls_nxt = JOB_NONE;
    job_kind_nxt = tcg_pkg::KIND_ROW;
    job_mode_nxt = tcg_pkg::MASK_ZERO;
    job_colour_nxt = in_ch.ink_colour;
    job_off_nxt = ({{(tcg_pkg::OFF_W - tcg_pkg::YW){1'b0}}, pos.y}
                   * {{(tcg_pkg::OFF_W - tcg_pkg::PITCH_W){1'b0}}, pitch_r})
                  + {{(tcg_pkg::OFF_W - tcg_pkg::XW){1'b0}}, pos.x};
    case (in_op)
      tcg_pkg::OP_PRINT: begin
        if (in_ch.char_code == tcg_pkg::CODE_NEWLINE) begin
          job_cls_nxt = pos.scroll ? JOB_SINGLE : JOB_NONE;
          job_kind_nxt = tcg_pkg::KIND_SCROLL;
          job_colour_nxt = '0;
          job_off_nxt = '0;
        end else begin
          job_cls_nxt = JOB_ROWS;
          if (in_ch.char_code == tcg_pkg::CODE_BLOCK) begin
            job_mode_nxt = tcg_pkg::MASK_ONES;
          end else if ({1'b0, in_ch.char_code} < 9'(GLYPH_COUNT)) begin
            job_mode_nxt = tcg_pkg::MASK_FONT;
          end
        end
      end
      tcg_pkg::OP_LOAD: begin
        job_cls_nxt = JOB_LOAD;
      end
      tcg_pkg::OP_CLEAR: begin
        job_cls_nxt = JOB_SINGLE;
        job_kind_nxt = tcg_pkg::KIND_FILL;
        job_colour_nxt = clear_r;
        job_off_nxt = '0;
      end
      tcg_pkg::OP_ERASE: begin
        job_cls_nxt = JOB_ROWS;
        job_mode_nxt = tcg_pkg::MASK_ONES;
        job_colour_nxt = clear_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0;
      width_r <= 13'd640;
      height_r <= 13'd480;
      pitch_r <= 14'd640;
      clear_r <= '0;
      job_valid_r <= 1'b0;
      em_active_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr) begin
        case (paddr[5:3])
          tcg_pkg::REG_BASE:   base_r <= pwdata[tcg_pkg::ADDR_W-1:0];
          tcg_pkg::REG_WIDTH:  width_r <= pwdata[tcg_pkg::XW-1:0];
          tcg_pkg::REG_HEIGHT: height_r <= pwdata[tcg_pkg::XW-1:0];
          tcg_pkg::REG_PITCH:  pitch_r <= pwdata[tcg_pkg::PITCH_W-1:0];
          tcg_pkg::REG_CLEAR:  clear_r <= pwdata[tcg_pkg::COLOUR_W-1:0];
          default: begin
          end
        endcase
      end

      if (in_take) begin
        job_valid_r <= 1'b1;
        job_cls_r <= job_cls_nxt;
        job_kind_r <= job_kind_nxt;
        job_mode_r <= job_mode_nxt;
        job_colour_r <= job_colour_nxt;
        job_off_r <= job_off_nxt;
        job_faddr_r <= faddr_full[FONT_AW-1:0];
        job_fidx_r <= in_ch.font_index;
        job_fbyte_r <= in_ch.font_byte;
      end else if (job_take) begin
        job_valid_r <= 1'b0;
      end

      if (job_take && (job_cls_r == JOB_ROWS || job_cls_r == JOB_SINGLE)) begin
        em_active_r <= 1'b1;
        em_single_r <= (job_cls_r == JOB_SINGLE);
        em_cnt_r <= '0;
        em_kind_r <= job_kind_r;
        em_mode_r <= job_mode_r;
        em_colour_r <= job_colour_r;
        em_addr_r <= base_r + {{(tcg_pkg::ADDR_W - tcg_pkg::OFF_W - 2){1'b0}},
                               job_off_r, 2'b00};
        em_faddr_r <= job_faddr_r;
      end else if (em_step) begin
        em_cnt_r <= em_cnt_r + 1'b1;
        em_addr_r <= em_addr_r + stride;
        em_faddr_r <= em_faddr_r + 1'b1;
        if (em_last) begin
          em_active_r <= 1'b0;
        end
      end

      if (e2_adv) begin
        out_valid_r <= em_active_r;
        out_kind_r <= em_kind_r;
        out_mode_r <= row_mode;
        out_addr_r <= em_addr_r;
        out_colour_r <= em_colour_r;
        out_last_r <= em_last;
      end
    end
  end

  always_comb begin
    case (paddr[5:3])
      tcg_pkg::REG_BASE:   prdata = {16'b0, base_r};
      tcg_pkg::REG_WIDTH:  prdata = {51'b0, width_r};
      tcg_pkg::REG_HEIGHT: prdata = {51'b0, height_r};
      tcg_pkg::REG_PITCH:  prdata = {50'b0, pitch_r};
      tcg_pkg::REG_CLEAR:  prdata = {32'b0, clear_r};
      default:             prdata = '0;
    endcase
  end

  always_comb begin
    case (out_mode_r)
      tcg_pkg::MASK_FONT: out_ch.pixel_mask = font_q;
      tcg_pkg::MASK_ONES: out_ch.pixel_mask = 8'hFF;
      default:            out_ch.pixel_mask = 8'h00;
    endcase
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.kind = out_kind_r;
  assign out_ch.row_address = out_addr_r;
  assign out_ch.pixel_colour = out_colour_r;
  assign out_ch.last = out_last_r;

`ifndef SYNTHESIS
  a_single_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_kind_r != tcg_pkg::KIND_ROW |-> out_last_r)
    else $error("scroll or fill result without last");

  a_no_read_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |-> !em_step)
    else $error("font read while output stalled");

  a_rows_start: assert property (@(posedge clk) disable iff (!rst_n)
    job_take && job_cls_r == JOB_ROWS |=> em_active_r && em_cnt_r == '0 && !em_single_r)
    else $error("row job did not start at row zero");

  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    font_we |-> !em_active_r || (em_step && em_last))
    else $error("font write while glyph rows pending");
`endif

endmodule

[design/tcg_ram.sv]
module tcg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[design/tcg_cursor.sv]
module tcg_cursor (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   take,
  input  tcg_pkg::op_t           op,
  input  logic [7:0]             char_code,
  input  logic [tcg_pkg::XW-1:0] screen_width,
  input  logic [tcg_pkg::XW-1:0] screen_height,
  output tcg_pkg::cell_t         pos
);

  logic [tcg_pkg::XW-1:0] cursor_x_r, cursor_x_nxt;
  logic [tcg_pkg::YW-1:0] cursor_y_r, cursor_y_nxt;
  logic [tcg_pkg::YW-1:0] y_up, y_dn, y0, y0_dn;
  logic [tcg_pkg::XW-1:0] x_adv, x0;
  logic [8:0]             rows;

  assign y_up = cursor_y_r + tcg_pkg::CELL_H;
  assign y_dn = (cursor_y_r >= tcg_pkg::CELL_H) ? cursor_y_r - tcg_pkg::CELL_H : '0;
  assign x_adv = cursor_x_r + tcg_pkg::CELL_W;
  assign rows = screen_height[tcg_pkg::XW-1:4];
  assign x0 = (cursor_x_r == '0) ? screen_width : cursor_x_r;
  assign y0 = (cursor_x_r == '0) ? y_dn : cursor_y_r;
  assign y0_dn = (y0 >= tcg_pkg::CELL_H) ? y0 - tcg_pkg::CELL_H : '0;

  always_comb begin
    pos.x = cursor_x_r;
    pos.y = cursor_y_r;
    pos.scroll = 1'b0;
    cursor_x_nxt = cursor_x_r;
    cursor_y_nxt = cursor_y_r;
    case (op)
      tcg_pkg::OP_PRINT: begin
        if (char_code == tcg_pkg::CODE_NEWLINE) begin
          cursor_x_nxt = '0;
          if ({1'b0, y_up[tcg_pkg::YW-1:4]} + 13'd1 >= {4'b0, rows}) begin
            pos.scroll = 1'b1;
            cursor_y_nxt = cursor_y_r;
          end else begin
            cursor_y_nxt = y_up;
          end
        end else if ({1'b0, x_adv} + 14'd8 > {1'b0, screen_width}) begin
          cursor_x_nxt = '0;
          cursor_y_nxt = y_up;
        end else begin
          cursor_x_nxt = x_adv;
        end
      end
      tcg_pkg::OP_CLEAR: begin
        cursor_x_nxt = '0;
        cursor_y_nxt = '0;
      end
      tcg_pkg::OP_ERASE: begin
        pos.y = y0;
        if (x0 >= tcg_pkg::CELL_W) begin
          pos.x = x0 - tcg_pkg::CELL_W;
          cursor_x_nxt = x0 - tcg_pkg::CELL_W;
          cursor_y_nxt = y0;
        end else begin
          pos.x = '0;
          cursor_x_nxt = screen_width;
          cursor_y_nxt = y0_dn;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_x_r <= '0;
      cursor_y_r <= '0;
    end else if (take) begin
      cursor_x_r <= cursor_x_nxt;
      cursor_y_r <= cursor_y_nxt;
    end
  end

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

  localparam int DRAIN_CYCLES = 12;
  localparam int PHASE_ITEMS = 62;
  localparam int NUM_PHASES = 6;
  localparam int MAX_REPORTS = 10;
  localparam longint unsigned RUN_LIMIT_NS = 64'd20_000_000;

  typedef struct packed {
    tcg_pkg::op_t op;
    logic [7:0]   char_code;
    logic [31:0]  ink_colour;
    logic [11:0]  font_index;
    logic [7:0]   font_byte;
  } console_cmd_t;

  typedef struct packed {
    tcg_pkg::kind_t kind;
    logic [47:0]    row_address;
    logic [7:0]     pixel_mask;
    logic [31:0]    pixel_colour;
    logic           last;
  } fb_write_t;

  typedef struct packed {
    bit           is_cfg;
    logic [2:0]   reg_sel;
    logic [63:0]  reg_val;
    console_cmd_t cmd;
    bit           has_known;
    fb_write_t    known;
  } step_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [5:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;

  tcg_cmd_if in_ch();
  tcg_res_if out_ch();

  text_console_glyph_renderer uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk = ~clk;

  logic [47:0] sh_base;
  logic [12:0] sh_width;
  logic [12:0] sh_height;
  logic [13:0] sh_pitch;
  logic [31:0] sh_clear;
  logic [12:0] cur_x;
  logic [15:0] cur_y;
  logic [7:0]  glyph_rom [4096];
  logic [7:0]  loaded_glyphs[$];
  fb_write_t   pending_writes[$];

  int unsigned mismatches = 0;
  int unsigned n_checked = 0;
  int unsigned n_scrolls = 0;
  int unsigned n_fills = 0;
  int unsigned n_prints = 0;
  int unsigned n_erases = 0;
  int unsigned n_clears = 0;
  int unsigned n_loads = 0;
  int unsigned n_settings = 0;
  int unsigned rx_hold = 0;
  bit          rx_burst = 1'b0;
  bit          tx_burst = 1'b0;

  function automatic logic [47:0] cell_addr(int unsigned x, int unsigned y);
    logic [63:0] off;
    off = 64'(x) + 64'(y) * 64'(sh_pitch);
    return 48'(64'(sh_base) + 64'd4 * off);
  endfunction

  function automatic void push_write(tcg_pkg::kind_t k, logic [47:0] a, logic [7:0] m,
                                     logic [31:0] col, logic l);
    fb_write_t w;
    w.kind = k;
    w.row_address = a;
    w.pixel_mask = m;
    w.pixel_colour = col;
    w.last = l;
    pending_writes.push_back(w);
  endfunction

  function automatic void back_one_line();
    cur_x = sh_width;
    cur_y = (cur_y >= tcg_pkg::CELL_H) ? cur_y - tcg_pkg::CELL_H : '0;
  endfunction

  function automatic void render_cmd(console_cmd_t c);
    logic [12:0] cell_left;
    logic [7:0]  m;
    case (c.op)
      tcg_pkg::OP_LOAD: begin
        glyph_rom[c.font_index] = c.font_byte;
        n_loads++;
      end
      tcg_pkg::OP_CLEAR: begin
        push_write(tcg_pkg::KIND_FILL, sh_base, 8'h00, sh_clear, 1'b1);
        cur_x = '0;
        cur_y = '0;
        n_clears++;
      end
      tcg_pkg::OP_ERASE: begin
        if (cur_x == '0) back_one_line();
        cell_left = (cur_x >= tcg_pkg::CELL_W) ? cur_x - tcg_pkg::CELL_W : '0;
        for (int unsigned r = 0; r < 32'(tcg_pkg::CELL_H); r++) begin
          push_write(tcg_pkg::KIND_ROW, cell_addr(32'(cell_left), 32'(cur_y) + r),
                     8'hFF, sh_clear, 4'(r) == tcg_pkg::ROW_LAST);
        end
        if (cur_x < tcg_pkg::CELL_W) back_one_line();
        else cur_x = cur_x - tcg_pkg::CELL_W;
        n_erases++;
      end
      default: begin
        n_prints++;
        if (c.char_code == tcg_pkg::CODE_NEWLINE) begin
          cur_x = '0;
          cur_y = cur_y + tcg_pkg::CELL_H;
          if (32'(cur_y) / 16 + 1 >= 32'(sh_height) / 16) begin
            push_write(tcg_pkg::KIND_SCROLL, sh_base, 8'h00, 32'h0, 1'b1);
            cur_y = cur_y - tcg_pkg::CELL_H;
          end
        end else begin
          for (int unsigned r = 0; r < 32'(tcg_pkg::CELL_H); r++) begin
            m = (c.char_code == tcg_pkg::CODE_BLOCK) ? 8'hFF
                                                      : glyph_rom[{c.char_code, 4'(r)}];
            push_write(tcg_pkg::KIND_ROW, cell_addr(32'(cur_x), 32'(cur_y) + r), m,
                       c.ink_colour, 4'(r) == tcg_pkg::ROW_LAST);
          end
          cur_x = cur_x + tcg_pkg::CELL_W;
          if (32'(cur_x) + 32'(tcg_pkg::CELL_W) > 32'(sh_width)) begin
            cur_x = '0;
            cur_y = cur_y + tcg_pkg::CELL_H;
          end
        end
      end
    endcase
  endfunction

  function automatic console_cmd_t noise_cmd(tcg_pkg::op_t op);
    console_cmd_t c;
    c.op = op;
    c.char_code = 8'($urandom);
    c.ink_colour = $urandom;
    c.font_index = 12'($urandom);
    c.font_byte = 8'($urandom);
    return c;
  endfunction

  function automatic logic [7:0] pick_code();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 15) return tcg_pkg::CODE_NEWLINE;
    if (sel < 25 || loaded_glyphs.size() == 0) return tcg_pkg::CODE_BLOCK;
    return loaded_glyphs[$urandom_range(0, loaded_glyphs.size() - 1)];
  endfunction

  function automatic step_row_t cmd_row(tcg_pkg::op_t op, logic [7:0] code,
                                        logic [31:0] ink, logic [11:0] idx,
                                        logic [7:0] fb);
    step_row_t s;
    s = '0;
    s.cmd.op = op;
    s.cmd.char_code = code;
    s.cmd.ink_colour = ink;
    s.cmd.font_index = idx;
    s.cmd.font_byte = fb;
    return s;
  endfunction

  function automatic step_row_t cfg_row(logic [2:0] sel, logic [63:0] val);
    step_row_t s;
    s = '0;
    s.is_cfg = 1'b1;
    s.reg_sel = sel;
    s.reg_val = val;
    return s;
  endfunction

  function automatic step_row_t with_known(step_row_t s, tcg_pkg::kind_t k,
                                           logic [47:0] a, logic [7:0] m,
                                           logic [31:0] col, logic l);
    s.has_known = 1'b1;
    s.known.kind = k;
    s.known.row_address = a;
    s.known.pixel_mask = m;
    s.known.pixel_colour = col;
    s.known.last = l;
    return s;
  endfunction

  task automatic send_cmd(console_cmd_t c, bit has_known, fb_write_t known);
    int unsigned gap;
    int unsigned first;
    gap = tx_burst ? 0 : $urandom_range(0, 14);
    if ($urandom_range(0, 19) == 0) tx_burst = !tx_burst;
    if (gap != 0) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.op <= c.op;
    in_ch.char_code <= c.char_code;
    in_ch.ink_colour <= c.ink_colour;
    in_ch.font_index <= c.font_index;
    in_ch.font_byte <= c.font_byte;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    first = pending_writes.size();
    render_cmd(c);
    if (has_known) pending_writes[first] = known;
  endtask

  task automatic park_and_settle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] sel, logic [63:0] val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {sel, 3'b000};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (sel)
      tcg_pkg::REG_BASE:   sh_base = val[47:0];
      tcg_pkg::REG_WIDTH:  sh_width = val[12:0];
      tcg_pkg::REG_HEIGHT: sh_height = val[12:0];
      tcg_pkg::REG_PITCH:  sh_pitch = val[13:0];
      tcg_pkg::REG_CLEAR:  sh_clear = val[31:0];
      default: ;
    endcase
  endtask

  always @(negedge clk) begin
    if (!rst_n || rx_hold != 0) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    fb_write_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      n_checked++;
      if (out_ch.kind == tcg_pkg::KIND_SCROLL) n_scrolls++;
      if (out_ch.kind == tcg_pkg::KIND_FILL) n_fills++;
      if (pending_writes.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("[%0t] unexpected result: kind %0d addr %h mask %h colour %h last %b",
                   $realtime, out_ch.kind, out_ch.row_address, out_ch.pixel_mask,
                   out_ch.pixel_colour, out_ch.last);
      end else begin
        want = pending_writes.pop_front();
        if (out_ch.kind !== want.kind || out_ch.row_address !== want.row_address ||
            out_ch.pixel_mask !== want.pixel_mask ||
            out_ch.pixel_colour !== want.pixel_colour || out_ch.last !== want.last) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display({"[%0t] expected kind %0d addr %h mask %h colour %h last %b, ",
                      "got %0d %h %h %h %b"},
                     $realtime, want.kind, want.row_address, want.pixel_mask,
                     want.pixel_colour, want.last, out_ch.kind, out_ch.row_address,
                     out_ch.pixel_mask, out_ch.pixel_colour, out_ch.last);
        end
      end
      rx_hold = rx_burst ? 0 : $urandom_range(0, 14);
      if ($urandom_range(0, 19) == 0) rx_burst = !rx_burst;
    end else if (rx_hold != 0) begin
      rx_hold--;
    end
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    step_row_t    steps[$];
    console_cmd_t c;
    logic [7:0]   g;
    logic [63:0]  v_base;
    logic [63:0]  v_width;
    logic [63:0]  v_height;
    logic [63:0]  v_pitch;
    logic [63:0]  v_clear;
    int unsigned  sel;
    int unsigned  items;
    int unsigned  pause_at;
    bit           paused;

    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.op = '0;
    in_ch.char_code = '0;
    in_ch.ink_colour = '0;
    in_ch.font_index = '0;
    in_ch.font_byte = '0;
    sh_base = '0;
    sh_width = 13'd640;
    sh_height = 13'd480;
    sh_pitch = 14'd640;
    sh_clear = '0;
    cur_x = '0;
    cur_y = '0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    steps.push_back(with_known(cmd_row(tcg_pkg::OP_CLEAR, 8'h00, 32'h0, 12'h000, 8'h00),
                               tcg_pkg::KIND_FILL, 48'd0, 8'h00, 32'h0, 1'b1));
    steps.push_back(with_known(cmd_row(tcg_pkg::OP_ERASE, 8'hFF, 32'hFFFF_FFFF, 12'hFFF,
                                       8'hFF),
                               tcg_pkg::KIND_ROW, 48'd2528, 8'hFF, 32'h0, 1'b0));
    steps.push_back(with_known(cmd_row(tcg_pkg::OP_PRINT, tcg_pkg::CODE_BLOCK,
                                       32'hFFFF_FFFF, 12'h000, 8'h00),
                               tcg_pkg::KIND_ROW, 48'd2528, 8'hFF, 32'hFFFF_FFFF, 1'b0));
    for (int r = 0; r < 16; r++) begin
      case (r)
        0: g = 8'h80;
        1: g = 8'hFF;
        2: g = 8'h00;
        3: g = 8'h01;
        default: g = 8'(r * 37 + 5);
      endcase
      steps.push_back(cmd_row(tcg_pkg::OP_LOAD, 8'h00, 32'h0, {8'hFF, 4'(r)}, g));
    end
    loaded_glyphs.push_back(8'hFF);
    steps.push_back(with_known(cmd_row(tcg_pkg::OP_PRINT, 8'hFF, 32'h00FF_00FF, 12'h000,
                                       8'h00),
                               tcg_pkg::KIND_ROW, 48'd40960, 8'h80, 32'h00FF_00FF, 1'b0));
    steps.push_back(cmd_row(tcg_pkg::OP_PRINT, tcg_pkg::CODE_NEWLINE, 32'h0, 12'h000,
                            8'h00));
    steps.push_back(cmd_row(tcg_pkg::OP_ERASE, 8'h00, 32'h0, 12'h000, 8'h00));
    steps.push_back(cfg_row(tcg_pkg::REG_WIDTH, 64'd13));
    steps.push_back(cmd_row(tcg_pkg::OP_PRINT, tcg_pkg::CODE_BLOCK, 32'h1234_5678, 12'h000,
                            8'h00));
    steps.push_back(cmd_row(tcg_pkg::OP_ERASE, 8'h00, 32'h0, 12'h000, 8'h00));
    steps.push_back(cmd_row(tcg_pkg::OP_ERASE, 8'h00, 32'h0, 12'h000, 8'h00));
    steps.push_back(cfg_row(tcg_pkg::REG_HEIGHT, 64'd32));
    steps.push_back(with_known(cmd_row(tcg_pkg::OP_PRINT, tcg_pkg::CODE_NEWLINE, 32'h0,
                                       12'h000, 8'h00),
                               tcg_pkg::KIND_SCROLL, 48'd0, 8'h00, 32'h0, 1'b1));
    steps.push_back(cfg_row(tcg_pkg::REG_BASE, 64'hFFFF_FFFF_FFFF));
    steps.push_back(cfg_row(tcg_pkg::REG_CLEAR, 64'hA5A5_A5A5));
    steps.push_back(with_known(cmd_row(tcg_pkg::OP_ERASE, 8'h00, 32'h0, 12'h000, 8'h00),
                               tcg_pkg::KIND_ROW, 48'd19, 8'hFF, 32'hA5A5_A5A5, 1'b0));

    foreach (steps[i]) begin
      if (steps[i].is_cfg) begin
        park_and_settle();
        write_reg(steps[i].reg_sel, steps[i].reg_val);
        n_settings++;
      end else begin
        send_cmd(steps[i].cmd, steps[i].has_known, steps[i].known);
      end
    end

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      park_and_settle();
      v_base = {$urandom, $urandom} & 64'hFFFF_FFFF_FFFF;
      v_clear = 64'($urandom);
      case (phase)
        0: begin
          v_width = 64'd640;
          v_height = 64'd480;
          v_pitch = 64'd640;
        end
        1: begin
          v_base = 64'hFFFF_FFFF_FFFF;
          v_width = 64'd8;
          v_height = 64'd32;
          v_pitch = 64'd8;
          v_clear = 64'hFFFF_FFFF;
        end
        2: begin
          v_base = 64'd0;
          v_width = 64'd4096;
          v_height = 64'd4096;
          v_pitch = 64'd8192;
          v_clear = 64'd0;
        end
        4: begin
          v_width = 64'($urandom_range(8, 40));
          v_height = 64'($urandom_range(32, 80));
          v_pitch = 64'($urandom_range(8, 64));
        end
        default: begin
          v_width = 64'($urandom_range(8, 4096));
          v_height = 64'($urandom_range(32, 4096));
          v_pitch = 64'($urandom_range(8, 8192));
        end
      endcase
      write_reg(tcg_pkg::REG_BASE, v_base);
      write_reg(tcg_pkg::REG_WIDTH, v_width);
      write_reg(tcg_pkg::REG_HEIGHT, v_height);
      write_reg(tcg_pkg::REG_PITCH, v_pitch);
      write_reg(tcg_pkg::REG_CLEAR, v_clear);
      n_settings++;

      pause_at = $urandom_range(10, PHASE_ITEMS - 10);
      paused = 1'b0;
      items = 0;
      while (items < PHASE_ITEMS) begin
        if (!paused && items >= pause_at) begin
          park_and_settle();
          paused = 1'b1;
        end
        sel = $urandom_range(0, 99);
        if (sel < 10) begin
          g = 8'($urandom);
          for (int r = 0; r < 16; r++) begin
            c = noise_cmd(tcg_pkg::OP_LOAD);
            c.font_index = {g, 4'(r)};
            send_cmd(c, 1'b0, '0);
          end
          loaded_glyphs.push_back(g);
          items += 16;
        end else if (sel < 14) begin
          send_cmd(noise_cmd(tcg_pkg::OP_LOAD), 1'b0, '0);
          items++;
        end else if (sel < 58) begin
          c = noise_cmd(tcg_pkg::OP_PRINT);
          c.char_code = pick_code();
          send_cmd(c, 1'b0, '0);
          items++;
        end else if (sel < 86) begin
          send_cmd(noise_cmd(tcg_pkg::OP_ERASE), 1'b0, '0);
          items++;
        end else if (sel < 90) begin
          send_cmd(noise_cmd(tcg_pkg::OP_CLEAR), 1'b0, '0);
          items++;
        end else begin
          repeat ($urandom_range(1, 4)) begin
            c = noise_cmd(tcg_pkg::OP_PRINT);
            c.char_code = tcg_pkg::CODE_NEWLINE;
            send_cmd(c, 1'b0, '0);
            items++;
          end
        end
      end
    end

    park_and_settle();

    $display({"Run covered %0d commands (%0d prints, %0d erases, %0d clears, ",
              "%0d font loads) over %0d register settings."},
             n_prints + n_erases + n_clears + n_loads, n_prints, n_erases, n_clears, n_loads,
             n_settings);
    $display({"Checked %0d result transactions, %0d scrolls and %0d fills among them, ",
              "%0d mismatches."},
             n_checked, n_scrolls, n_fills, mismatches);
    if (mismatches == 0 && pending_writes.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
